// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

// ===== rtl/core/srfc_pkg.sv =====
// Package for the sensor reply frame checker.
// Holds payload structs, status codes, parser phases and header constants.
`default_nettype none

package srfc_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'hEF;
   localparam logic [7:0] HDR_SECOND = 8'h01;
   localparam logic [7:0] REPLY_ID   = 8'h07;

   // Address bytes that follow the header.
   localparam logic [15:0] ADDR_BYTES = 16'd4;
   // Length field counts the two checksum bytes as well.
   localparam logic [15:0] CHECKSUM_BYTES = 16'd2;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_CHECKSUM  = 3'd1,
      STATUS_NO_HEADER = 3'd2,
      STATUS_BAD_LEN   = 3'd3,
      STATUS_TRUNCATED = 3'd4
   } status_type;

   typedef enum logic [7:0] {
      PH_HUNT = 8'b0000_0001,
      PH_ADDR = 8'b0000_0010,
      PH_PID  = 8'b0000_0100,
      PH_LENH = 8'b0000_1000,
      PH_LENL = 8'b0001_0000,
      PH_DATA = 8'b0010_0000,
      PH_CHKH = 8'b0100_0000,
      PH_CHKL = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  frame_id;
      logic [7:0]  confirm_code;
      logic [15:0] frame_length;
   } rsp_payload_type;

   // Result of one parser step: whether a result leaves, and its contents.
   typedef struct packed {
      logic            emit;
      rsp_payload_type data;
   } step_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/sensor_reply_frame_checker_top.sv =====
// Sensor reply frame checker, top level.
// Serial bytes enter on the req_ channel: rx_byte plus buffer_end, which marks
// the last byte of a received buffer. The block finds the EF 01 header, skips
// four address bytes, reads the identifier and the 16-bit length, sums the
// identifier, length and data bytes and compares the sum with the trailing
// big-endian checksum.
// The rsp_ channel carries at most one result per byte: a finished frame (ok or
// checksum error), a bad length, a buffer with no header, or a frame cut off by
// the buffer end. Bytes that give no result produce no transfer.
// A result passes the input register, then the parse logic into the result
// register. Throughput: one byte per cycle unless a stalled receiver holds
// the result register; the phase machine steps once per byte.
// Reset empties both registers and clears the parser; it then hunts for a header.
// While the receiver stalls, the held result stays; the next byte still
// enters the input register, and req_stall rises only once that register
// holds a byte whose step cannot complete.
// Depends on srfc_pkg and the srfc_in_stage, srfc_parser and srfc_out_stage.
`default_nettype none

module sensor_reply_frame_checker_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire srfc_pkg::req_payload_type req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output srfc_pkg::rsp_payload_type      rsp_data
);

   logic                      item_valid;
   srfc_pkg::req_payload_type item_data;
   srfc_pkg::step_result_type result;
   logic                      slot_free;
   logic                      advance;

   // A byte steps through the parser only when the result register can take it.
   assign advance = item_valid && slot_free;

   srfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   srfc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item_data (item_data),
      .result    (result)
   );

   srfc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/srfc_in_stage.sv =====
// Input register of the sensor reply frame checker.
// Depends on srfc_pkg for the request payload type.
`default_nettype none

module srfc_in_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire srfc_pkg::req_payload_type req_data,
   input  wire logic                     advance,
   output logic                          item_valid,
   output srfc_pkg::req_payload_type     item_data
);

   logic                      valid_ff;
   logic                      valid_in;
   srfc_pkg::req_payload_type data_ff;

   // The register takes a new transfer when empty or when its item moves on.
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/srfc_parser.sv =====
// Frame parser of the sensor reply frame checker: phase machine, running sum
// and captured fields, advanced one byte per step. Depends on srfc_pkg.
`default_nettype none

module srfc_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire srfc_pkg::req_payload_type item_data,
   output srfc_pkg::step_result_type      result
);

   srfc_pkg::phase_type phase_ff, phase_in;
   logic        prev_ef_ff, prev_ef_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  chk_high_ff, chk_high_in;
   logic [7:0]  ident_ff, ident_in;
   logic [7:0]  first_ff, first_in;
   logic        seen_ff, seen_in;

   logic [7:0]  rx;
   logic [15:0] sum_add;
   logic [15:0] count_inc;
   logic [15:0] len_low;

   assign rx        = item_data.rx_byte;
   assign sum_add   = sum_ff + {8'h00, rx};
   assign count_inc = count_ff + 16'd1;
   assign len_low   = {length_ff[15:8], rx};

   always_comb begin
      phase_in    = phase_ff;
      prev_ef_in  = prev_ef_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      chk_high_in = chk_high_ff;
      ident_in    = ident_ff;
      first_in    = first_ff;
      seen_in     = seen_ff;
      result      = '0;

      case (phase_ff)
         srfc_pkg::PH_HUNT: begin
            if (prev_ef_ff && rx == srfc_pkg::HDR_SECOND) begin
               count_in    = '0;
               length_in   = '0;
               sum_in      = '0;
               chk_high_in = '0;
               ident_in    = '0;
               first_in    = '0;
               phase_in    = srfc_pkg::PH_ADDR;
               prev_ef_in  = 1'b0;
            end else begin
               prev_ef_in = (rx == srfc_pkg::HDR_FIRST);
            end
         end
         srfc_pkg::PH_ADDR: begin
            if (count_inc >= srfc_pkg::ADDR_BYTES) begin
               count_in = '0;
               phase_in = srfc_pkg::PH_PID;
            end else begin
               count_in = count_inc;
            end
         end
         srfc_pkg::PH_PID: begin
            ident_in = rx;
            sum_in   = sum_add;
            phase_in = srfc_pkg::PH_LENH;
         end
         srfc_pkg::PH_LENH: begin
            length_in = {rx, 8'h00};
            sum_in    = sum_add;
            phase_in  = srfc_pkg::PH_LENL;
         end
         srfc_pkg::PH_LENL: begin
            length_in = len_low;
            sum_in    = sum_add;
            count_in  = '0;
            if (len_low < srfc_pkg::CHECKSUM_BYTES) begin
               result.emit              = 1'b1;
               result.data.status       = srfc_pkg::STATUS_BAD_LEN;
               result.data.frame_id     = ident_ff;
               result.data.confirm_code = '0;
               result.data.frame_length = len_low;
               seen_in    = 1'b1;
               phase_in   = srfc_pkg::PH_HUNT;
               prev_ef_in = 1'b0;
            end else if (len_low == srfc_pkg::CHECKSUM_BYTES) begin
               phase_in = srfc_pkg::PH_CHKH;
            end else begin
               phase_in = srfc_pkg::PH_DATA;
            end
         end
         srfc_pkg::PH_DATA: begin
            if (count_ff == 16'd0) begin
               first_in = rx;
            end
            sum_in   = sum_add;
            count_in = count_inc;
            if (count_inc >= length_ff - srfc_pkg::CHECKSUM_BYTES) begin
               phase_in = srfc_pkg::PH_CHKH;
            end
         end
         srfc_pkg::PH_CHKH: begin
            chk_high_in = rx;
            phase_in    = srfc_pkg::PH_CHKL;
         end
         srfc_pkg::PH_CHKL: begin
            result.emit              = 1'b1;
            result.data.status       = ({chk_high_ff, rx} == sum_ff) ?
                                       srfc_pkg::STATUS_OK : srfc_pkg::STATUS_CHECKSUM;
            result.data.frame_id     = ident_ff;
            result.data.confirm_code = first_ff;
            result.data.frame_length = length_ff;
            seen_in    = 1'b1;
            phase_in   = srfc_pkg::PH_HUNT;
            prev_ef_in = 1'b0;
         end
         default: begin
            phase_in = srfc_pkg::PH_HUNT;
         end
      endcase

      // A buffer end reports a frameless buffer or a cut-off frame, then starts over.
      if (item_data.buffer_end) begin
         if (!result.emit) begin
            if (phase_in == srfc_pkg::PH_HUNT) begin
               if (!seen_in) begin
                  result.emit        = 1'b1;
                  result.data.status = srfc_pkg::STATUS_NO_HEADER;
               end
            end else begin
               result.emit              = 1'b1;
               result.data.status       = srfc_pkg::STATUS_TRUNCATED;
               result.data.frame_id     = ident_in;
               result.data.confirm_code = first_in;
               result.data.frame_length = length_in;
            end
         end
         phase_in    = srfc_pkg::PH_HUNT;
         prev_ef_in  = 1'b0;
         count_in    = '0;
         length_in   = '0;
         sum_in      = '0;
         chk_high_in = '0;
         ident_in    = '0;
         first_in    = '0;
         seen_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= srfc_pkg::PH_HUNT;
         prev_ef_ff  <= 1'b0;
         count_ff    <= '0;
         length_ff   <= '0;
         sum_ff      <= '0;
         chk_high_ff <= '0;
         ident_ff    <= '0;
         first_ff    <= '0;
         seen_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         prev_ef_ff  <= prev_ef_in;
         count_ff    <= count_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         chk_high_ff <= chk_high_in;
         ident_ff    <= ident_in;
         first_ff    <= first_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/srfc_out_stage.sv =====
// Result register of the sensor reply frame checker.
// Depends on srfc_pkg for the step result and response payload types.
`default_nettype none

module srfc_out_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire srfc_pkg::step_result_type result,
   output logic                           slot_free,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output srfc_pkg::rsp_payload_type      rsp_data
);

   logic                      valid_ff;
   logic                      valid_in;
   logic                      load;
   srfc_pkg::rsp_payload_type data_ff;

   // The register is free when empty or when its transfer completes now.
   assign slot_free = !valid_ff || !rsp_stall;
   assign load      = advance && result.emit;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/srfc_checker.sv =====
// Port-level checks on the result channel of the sensor reply frame checker.
// Depends on srfc_pkg and assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"

module srfc_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire srfc_pkg::rsp_payload_type rsp_data
);

   logic held;
   logic no_header_seen;
   logic bad_len_seen;
   logic frame_done_seen;
   logic fields_empty;
   logic bad_len_fields;

   assign held            = rsp_valid && rsp_stall;
   assign no_header_seen  = rsp_valid && rsp_data.status == srfc_pkg::STATUS_NO_HEADER;
   assign bad_len_seen    = rsp_valid && rsp_data.status == srfc_pkg::STATUS_BAD_LEN;
   assign frame_done_seen = rsp_valid && (rsp_data.status == srfc_pkg::STATUS_OK ||
                                          rsp_data.status == srfc_pkg::STATUS_CHECKSUM);
   assign fields_empty    = rsp_data.frame_id == 8'h00 && rsp_data.confirm_code == 8'h00 &&
                            rsp_data.frame_length == 16'h0000;
   assign bad_len_fields  = rsp_data.frame_length < 16'd2 && rsp_data.confirm_code == 8'h00;

   `ASSERT_NEXT_CYCLE(a_rsp_valid_held, clock, reset, held, rsp_valid)
   `ASSERT_NEXT_CYCLE(a_rsp_data_held, clock, reset, held, $stable(rsp_data))
   `ASSERT_SAME_CYCLE(a_no_header_empty, clock, reset, no_header_seen, fields_empty)
   `ASSERT_SAME_CYCLE(a_bad_len_short, clock, reset, bad_len_seen, bad_len_fields)
   `ASSERT_SAME_CYCLE(a_frame_len_valid, clock, reset, frame_done_seen, rsp_data.frame_length >= 16'd2)

endmodule

bind sensor_reply_frame_checker_top srfc_checker u_srfc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== test/srfc_verdict_tracker_pkg.sv =====
// Scoreboard class for the sensor reply frame checker testbench.
// Tracks the frame parser's state and queues each expected result.
// Depends on srfc_pkg for the payload structs, status codes and phases.
`timescale 1ns / 100ps

package srfc_verdict_tracker_pkg;
   import srfc_pkg::*;

   class frame_verdict_tracker;
      rsp_payload_type expected_verdicts[$];
      int unsigned     mismatches;

      phase_type   parse_phase;
      bit          saw_ef;
      bit          verdict_given;
      logic [15:0] count;
      logic [15:0] frame_len;
      logic [15:0] sum;
      logic [7:0]  check_high;
      logic [7:0]  ident;
      logic [7:0]  first_byte;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void clear_frame();
         count = '0;
         frame_len = '0;
         sum = '0;
         check_high = '0;
         ident = '0;
         first_byte = '0;
      endfunction

      function void restart();
         parse_phase = PH_HUNT;
         saw_ef = 1'b0;
         verdict_given = 1'b0;
         clear_frame();
      endfunction

      function void push_verdict(status_type st, logic [7:0] pid, logic [7:0] code,
                                 logic [15:0] len);
         rsp_payload_type verdict;
         verdict.status = st;
         verdict.frame_id = pid;
         verdict.confirm_code = code;
         verdict.frame_length = len;
         expected_verdicts.push_back(verdict);
      endfunction

      // Advances the parser by one accepted byte and queues what it produces.
      function void note_byte(req_payload_type item);
         logic [7:0]  b;
         logic [15:0] received;
         bit          produced;
         b = item.rx_byte;
         produced = 1'b0;
         case (parse_phase)
            PH_HUNT: begin
               if (saw_ef && b == HDR_SECOND) begin
                  clear_frame();
                  parse_phase = PH_ADDR;
                  saw_ef = 1'b0;
               end else begin
                  saw_ef = (b == HDR_FIRST);
               end
            end
            PH_ADDR: begin
               count = count + 16'd1;
               if (count >= ADDR_BYTES) begin
                  count = '0;
                  parse_phase = PH_PID;
               end
            end
            PH_PID: begin
               ident = b;
               sum = sum + 16'(b);
               parse_phase = PH_LENH;
            end
            PH_LENH: begin
               frame_len = {b, 8'h00};
               sum = sum + 16'(b);
               parse_phase = PH_LENL;
            end
            PH_LENL: begin
               frame_len = {frame_len[15:8], b};
               sum = sum + 16'(b);
               count = '0;
               if (frame_len < CHECKSUM_BYTES) begin
                  push_verdict(STATUS_BAD_LEN, ident, 8'h00, frame_len);
                  produced = 1'b1;
                  verdict_given = 1'b1;
                  parse_phase = PH_HUNT;
                  saw_ef = 1'b0;
               end else if (frame_len == CHECKSUM_BYTES) begin
                  parse_phase = PH_CHKH;
               end else begin
                  parse_phase = PH_DATA;
               end
            end
            PH_DATA: begin
               if (count == 16'd0) first_byte = b;
               sum = sum + 16'(b);
               count = count + 16'd1;
               if (count >= frame_len - CHECKSUM_BYTES) parse_phase = PH_CHKH;
            end
            PH_CHKH: begin
               check_high = b;
               parse_phase = PH_CHKL;
            end
            default: begin
               received = {check_high, b};
               push_verdict((received == sum) ? STATUS_OK : STATUS_CHECKSUM,
                            ident, first_byte, frame_len);
               produced = 1'b1;
               verdict_given = 1'b1;
               parse_phase = PH_HUNT;
               saw_ef = 1'b0;
            end
         endcase
         if (item.buffer_end) begin
            if (!produced) begin
               if (parse_phase == PH_HUNT) begin
                  if (!verdict_given) push_verdict(STATUS_NO_HEADER, '0, '0, '0);
               end else begin
                  push_verdict(STATUS_TRUNCATED, ident, first_byte, frame_len);
               end
            end
            restart();
         end
      endfunction

      function void check_verdict(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d id %h code %h length %h",
                        got.status, got.frame_id, got.confirm_code, got.frame_length);
         end else begin
            want = expected_verdicts.pop_front();
            if (got.status !== want.status || got.frame_id !== want.frame_id ||
                got.confirm_code !== want.confirm_code ||
                got.frame_length !== want.frame_length) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected status %0d id %h code %h length %h,",
                            " got status %0d id %h code %h length %h"},
                           want.status, want.frame_id, want.confirm_code,
                           want.frame_length, got.status, got.frame_id,
                           got.confirm_code, got.frame_length);
            end
         end
      endfunction
   endclass

endpackage

// ===== test/sensor_reply_frame_checker_top_test.sv =====
// Testbench top for the sensor reply frame checker.
// Drives byte buffers with random idling and stalls and checks every result.
// Depends on srfc_pkg, srfc_verdict_tracker_pkg and sensor_reply_frame_checker_top.
`timescale 1ns / 100ps

module sensor_reply_frame_checker_top_test;
   import srfc_pkg::*;
   import srfc_verdict_tracker_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 1050;
   localparam int unsigned IDLE_PERCENT   = 20;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES   = 20;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   frame_verdict_tracker tracker;
   logic [7:0]  stream_bytes[$];
   int unsigned accepted_bytes = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_request = 1'b0;
   bit          calm = 1'b0;

   sensor_reply_frame_checker_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: checks each transfer, then picks the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_verdict(rsp_data);
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sensor_reply_frame_checker_top verification failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit last);
      req_payload_type item;
      item.rx_byte = b;
      item.buffer_end = last;
      if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tracker.note_byte(item);
      accepted_bytes++;
   endtask

   // Sends the collected buffer; its last byte carries buffer_end.
   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++)
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      stream_bytes.delete();
   endtask

   function automatic void append_noise(int unsigned n);
      repeat (n) begin
         if ($urandom_range(0, 99) < 15) stream_bytes.push_back(HDR_FIRST);
         else stream_bytes.push_back(8'($urandom()));
      end
   endfunction

   // Header, address, identifier, length and data_count data bytes; the checksum
   // follows only when the data fills the length field.
   function automatic void append_frame(int unsigned len_field, int unsigned data_count,
                                        bit corrupt);
      logic [15:0] sum;
      logic [15:0] len;
      logic [7:0]  pid;
      logic [7:0]  d;
      len = len_field[15:0];
      pid = ($urandom_range(0, 99) < 70) ? REPLY_ID : 8'($urandom());
      stream_bytes.push_back(HDR_FIRST);
      stream_bytes.push_back(HDR_SECOND);
      repeat (ADDR_BYTES) stream_bytes.push_back(8'($urandom()));
      stream_bytes.push_back(pid);
      stream_bytes.push_back(len[15:8]);
      stream_bytes.push_back(len[7:0]);
      sum = 16'(pid) + 16'(len[15:8]) + 16'(len[7:0]);
      repeat (data_count) begin
         d = 8'($urandom());
         stream_bytes.push_back(d);
         sum = sum + 16'(d);
      end
      if (len_field >= 2 && data_count == len_field - 2) begin
         if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
         stream_bytes.push_back(sum[15:8]);
         stream_bytes.push_back(sum[7:0]);
      end
   endfunction

   function automatic int unsigned data_size();
      if ($urandom_range(0, 99) < 90) return $urandom_range(0, 8);
      return $urandom_range(9, 40);
   endfunction

   function automatic void build_buffer();
      int unsigned kind;
      int unsigned n;
      int unsigned len;
      int unsigned start_size;
      int unsigned added;
      bit          complete;
      if ($urandom_range(0, 99) < 8) begin
         append_noise($urandom_range(1, 4));
         return;
      end
      append_noise($urandom_range(0, 2));
      repeat ($urandom_range(1, 3)) begin
         kind = $urandom_range(0, 99);
         n = data_size();
         if (kind < 65) append_frame(n + 2, n, 1'b0);
         else if (kind < 78) append_frame(n + 2, n, 1'b1);
         else if (kind < 88) append_frame($urandom_range(0, 1), 0, 1'b0);
         else append_noise($urandom_range(1, 3));
      end
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
         append_noise($urandom_range(1, 3));
      end else if (kind < 45) begin
         // Cut a frame off with the buffer end, sometimes under a huge length.
         if ($urandom_range(0, 1) == 1) begin
            len = $urandom_range(2, 65535);
            n = $urandom_range(0, 6);
            if (n > len - 2) n = len - 2;
         end else begin
            n = data_size();
            len = n + 2;
         end
         complete = (n == len - 2);
         start_size = stream_bytes.size();
         append_frame(len, n, 1'b0);
         added = stream_bytes.size() - start_size;
         repeat ($urandom_range(complete ? 1 : 0, added - 3)) void'(stream_bytes.pop_back());
      end
   endfunction

   initial begin
      int unsigned calm_end;
      bit          calm_done;
      bit          hold_done;
      bit          pause_done;
      calm_end = 0;
      calm_done = 1'b0;
      hold_done = 1'b0;
      pause_done = 1'b0;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Buffers with no header at all.
      stream_bytes = '{8'hFF};
      send_stream();
      stream_bytes = '{8'h00};
      send_stream();
      // Overlapping header followed by a length of one.
      stream_bytes = '{HDR_FIRST, HDR_FIRST, HDR_SECOND, 8'h00, 8'hFF, 8'h00, 8'hFF,
                       REPLY_ID, 8'h00, 8'h01};
      send_stream();
      // Frame with no data bytes; the buffer ends right after it.
      stream_bytes = '{HDR_FIRST, HDR_SECOND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'h00, 8'h02, 8'h00, 8'h02};
      send_stream();

      while (accepted_bytes < RANDOM_ITEMS) begin
         if (!calm_done && accepted_bytes >= 300) begin
            calm_done = 1'b1;
            calm = 1'b1;
            calm_end = accepted_bytes + 250;
         end
         if (calm && accepted_bytes >= calm_end) calm = 1'b0;
         if (!hold_done && accepted_bytes >= 600) begin
            // Single-byte buffers each give a result, so the block backs up.
            hold_done = 1'b1;
            hold_request = 1'b1;
            repeat (30) begin
               append_noise(1);
               send_stream();
            end
         end
         if (!pause_done && accepted_bytes >= 800) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            while (tracker.expected_verdicts.size() != 0) @(posedge clock);
         end
         build_buffer();
         send_stream();
      end

      req_valid <= 1'b0;
      while (tracker.expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_verdicts.size() == 0)
         $display("sensor_reply_frame_checker_top verification clean");
      else
         $display("sensor_reply_frame_checker_top verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/srfc_pkg.sv
rtl/core/srfc_in_stage.sv
rtl/core/srfc_parser.sv
rtl/core/srfc_out_stage.sv
rtl/core/sensor_reply_frame_checker_top.sv
rtl/core/srfc_checker.sv
test/srfc_verdict_tracker_pkg.sv
test/sensor_reply_frame_checker_top_test.sv
